FILE: hw/rtl/ecbu_pkg.sv
// Shared constants, types and rounding helpers for the camera basis core.
`timescale 1ns / 1ps

package ecbu_pkg;

  // Angles in Q.8 degrees
  localparam int FullTurn  = 92160;
  localparam int HalfTurn  = 46080;
  localparam int PitchLim  = 22784;
  // CORDIC angles in Q.16 degrees
  localparam int Deg90     = 5898240;
  localparam int Deg180    = 11796480;
  localparam int CordGain  = 652032874;
  localparam int OneQ30    = 1073741824;
  localparam int Q14Max    = 16384;
  localparam int CordSteps = 16;
  localparam logic [15:0] SensReset = 16'd5243;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [24:0] zang_t;
  typedef logic signed [22:0] wide_ang_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SENS  = 2'd0,
    CFG_CLAMP = 2'd1
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       sel_pitch;
    logic       yaw_add;
    logic       pitch_add;
    logic       pitch_clamp;
    logic       wrap_step;
    logic       yaw_store;
    logic       pitch_store;
    logic       cor_init;
    logic       cor_step;
    logic [3:0] step_idx;
    logic       save_yaw;
    logic       save_pitch;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       res_en;
    logic [1:0] res_idx;
    logic       load_out;
  } ecbu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic wrap_ok;
  } ecbu_sts_t;

  // Arctangent of 2^-i in Q.16 degrees
  function automatic zang_t atan_q16(input logic [3:0] i);
    zang_t r;
    case (i)
      4'd0:    r = 25'sd2949120;
      4'd1:    r = 25'sd1740967;
      4'd2:    r = 25'sd919879;
      4'd3:    r = 25'sd466945;
      4'd4:    r = 25'sd234379;
      4'd5:    r = 25'sd117304;
      4'd6:    r = 25'sd58666;
      4'd7:    r = 25'sd29335;
      4'd8:    r = 25'sd14668;
      4'd9:    r = 25'sd7334;
      4'd10:   r = 25'sd3667;
      4'd11:   r = 25'sd1833;
      4'd12:   r = 25'sd917;
      4'd13:   r = 25'sd458;
      4'd14:   r = 25'sd229;
      default: r = 25'sd115;
    endcase
    return r;
  endfunction

  // Round a Q.30 value to Q2.14 and saturate
  function automatic logic signed [15:0] q14_from30(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd32768) >>> 16;
    if (r > 33'sd16384) r = 33'sd16384;
    else if (r < -33'sd16384) r = -33'sd16384;
    return r[15:0];
  endfunction

  // Round a Q.60 product to Q2.14 and saturate
  function automatic logic signed [15:0] q14_from60(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > 64'sd16384) r = 64'sd16384;
    else if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction

endpackage

FILE: hw/rtl/euler_camera_basis_update_core.sv
// Top level of the yaw/pitch camera basis core with its configuration registers.
`timescale 1ns / 1ps

// Each accepted word (a mouse delta pair) updates the stored yaw and pitch and
// yields one word holding the unit front, right and up vectors in Q2.14 plus
// the new angles in Q.8 degrees. One word is in flight at a time. The work
// is the angle update, the two 16-step passes of the single shared CORDIC
// and the product pass on one 32x32 multiplier. With pitch clamping off,
// the pitch also goes through the wrap unit. The angle wrap removes one
// full turn per cycle and repeats until the angle lies within one turn.
// A finished word sits in the output register, so the next delta pair is
// taken while it waits.
// Configuration writes are always ready and should occur only while idle.
module euler_camera_basis_update_core import ecbu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [12:0] delta_x_i,
  input  logic signed [12:0] delta_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic [16:0]        yaw_now_o,
  output logic signed [16:0] pitch_now_o
);

  logic [15:0] sens_q;
  logic        clamp_q;
  ecbu_cmd_t   cmd;
  ecbu_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= SensReset;
      clamp_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SENS:  sens_q  <= cfg_data_i;
        CFG_CLAMP: clamp_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  ecbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .clamp_i     (clamp_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ecbu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sens_i      (sens_q),
    .delta_x_i   (delta_x_i),
    .delta_y_i   (delta_y_i),
    .front_x_o   (front_x_o),
    .front_y_o   (front_y_o),
    .front_z_o   (front_z_o),
    .right_x_o   (right_x_o),
    .right_z_o   (right_z_o),
    .up_x_o      (up_x_o),
    .up_y_o      (up_y_o),
    .up_z_o      (up_z_o),
    .yaw_now_o   (yaw_now_o),
    .pitch_now_o (pitch_now_o)
  );

endmodule

FILE: hw/rtl/ecbu_ctrl.sv
// Sequencer for the angle update, the shared CORDIC and the product pass.
`timescale 1ns / 1ps

module ecbu_ctrl import ecbu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  logic      clamp_i,
  input  ecbu_sts_t sts_i,
  output ecbu_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_YAW_ADD    = 13'b0000000000010,
    S_YAW_WRAP   = 13'b0000000000100,
    S_PITCH_ADD  = 13'b0000000001000,
    S_PITCH_WRAP = 13'b0000000010000,
    S_YAW_INIT   = 13'b0000000100000,
    S_YAW_ROT    = 13'b0000001000000,
    S_YAW_SAVE   = 13'b0000010000000,
    S_PIT_INIT   = 13'b0000100000000,
    S_PIT_ROT    = 13'b0001000000000,
    S_PIT_SAVE   = 13'b0010000000000,
    S_MUL        = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_YAW_ADD;
        end
      end
      S_YAW_ADD: begin
        cmd_o.yaw_add = 1'b1;
        state_d = S_YAW_WRAP;
      end
      S_YAW_WRAP: begin
        cmd_o.wrap_step = 1'b1;
        if (sts_i.wrap_ok) begin
          cmd_o.yaw_store = 1'b1;
          state_d = S_PITCH_ADD;
        end
      end
      S_PITCH_ADD: begin
        cmd_o.sel_pitch = 1'b1;
        if (clamp_i) begin
          cmd_o.pitch_clamp = 1'b1;
          state_d = S_YAW_INIT;
        end else begin
          cmd_o.pitch_add = 1'b1;
          state_d = S_PITCH_WRAP;
        end
      end
      S_PITCH_WRAP: begin
        cmd_o.wrap_step = 1'b1;
        if (sts_i.wrap_ok) begin
          cmd_o.pitch_store = 1'b1;
          state_d = S_YAW_INIT;
        end
      end
      S_YAW_INIT: begin
        cmd_o.cor_init = 1'b1;
        cnt_d = '0;
        state_d = S_YAW_ROT;
      end
      S_YAW_ROT: begin
        cmd_o.cor_step = 1'b1;
        cmd_o.step_idx = cnt_q;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(CordSteps - 1)) state_d = S_YAW_SAVE;
      end
      S_YAW_SAVE: begin
        cmd_o.save_yaw = 1'b1;
        state_d = S_PIT_INIT;
      end
      S_PIT_INIT: begin
        cmd_o.cor_init  = 1'b1;
        cmd_o.sel_pitch = 1'b1;
        cnt_d = '0;
        state_d = S_PIT_ROT;
      end
      S_PIT_ROT: begin
        cmd_o.cor_step = 1'b1;
        cmd_o.step_idx = cnt_q;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(CordSteps - 1)) state_d = S_PIT_SAVE;
      end
      S_PIT_SAVE: begin
        cmd_o.save_pitch = 1'b1;
        cnt_d = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        // issue four products, store each in the following cycle
        cmd_o.mul_en  = (cnt_q < 4'd4);
        cmd_o.mul_idx = cnt_q[1:0];
        cmd_o.res_en  = (cnt_q != 4'd0);
        cmd_o.res_idx = cnt_q[1:0] - 2'd1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd4) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/ecbu_datapath.sv
// Angle registers, wrap unit, shared CORDIC, multiplier and output registers.
`timescale 1ns / 1ps

module ecbu_datapath import ecbu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecbu_cmd_t           cmd_i,
  output ecbu_sts_t           sts_o,
  input  logic [15:0]         sens_i,
  input  logic signed [12:0]  delta_x_i,
  input  logic signed [12:0]  delta_y_i,
  output logic signed [15:0]  front_x_o,
  output logic signed [15:0]  front_y_o,
  output logic signed [15:0]  front_z_o,
  output logic signed [15:0]  right_x_o,
  output logic signed [15:0]  right_z_o,
  output logic signed [15:0]  up_x_o,
  output logic signed [15:0]  up_y_o,
  output logic signed [15:0]  up_z_o,
  output logic [16:0]         yaw_now_o,
  output logic signed [16:0]  pitch_now_o
);

  localparam wide_ang_t FullW  = wide_ang_t'(FullTurn);
  localparam wide_ang_t HalfW  = wide_ang_t'(HalfTurn);
  localparam wide_ang_t LimW   = wide_ang_t'(PitchLim);
  localparam zang_t     Deg90Z = zang_t'(Deg90);
  localparam zang_t     Deg180Z = zang_t'(Deg180);
  localparam trig_t     OneT   = trig_t'(OneQ30);

  logic signed [12:0] dx_q, dy_q;
  logic [16:0]        yaw_q;
  logic signed [16:0] pitch_q;
  wide_ang_t          w_q;
  trig_t              x_q, y_q;
  zang_t              z_q;
  logic               flip_q;
  trig_t              cy_q, sy_q, cp_q, sp_q;
  logic signed [63:0] prod_q;
  logic signed [15:0] fx_q, fz_q, ux_q, uz_q;

  // Scale the selected delta and round to Q.8
  logic signed [12:0] delta;
  logic signed [29:0] scl;
  logic signed [21:0] dang;
  wide_ang_t          ysum, psum;

  assign delta = cmd_i.sel_pitch ? dy_q : dx_q;
  assign scl   = 30'(delta) * $signed({14'd0, sens_i}) + 30'sd128;
  assign dang  = scl[29:8];
  assign ysum  = $signed({6'd0, yaw_q}) + {dang[21], dang};
  assign psum  = {{6{pitch_q[16]}}, pitch_q} + {dang[21], dang};

  // Wrap by one turn per cycle
  wide_ang_t w_step;
  always_comb begin
    if (w_q < 0) w_step = w_q + FullW;
    else if (w_q >= FullW) w_step = w_q - FullW;
    else w_step = w_q;
  end
  assign sts_o.wrap_ok = (w_q >= 0) && (w_q < FullW);

  wide_ang_t psat, pwrap;
  always_comb begin
    if (psum > LimW) psat = LimW;
    else if (psum < -LimW) psat = -LimW;
    else psat = psum;
    pwrap = w_q - HalfW;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q <= delta_x_i;
      dy_q <= delta_y_i;
    end
    if (cmd_i.yaw_add) w_q <= ysum;
    else if (cmd_i.pitch_add) w_q <= psum + HalfW;
    else if (cmd_i.wrap_step) w_q <= w_step;
  end

  // Angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
    end else begin
      if (cmd_i.yaw_store) yaw_q <= w_q[16:0];
      if (cmd_i.pitch_clamp) pitch_q <= psat[16:0];
      else if (cmd_i.pitch_store) pitch_q <= pwrap[16:0];
    end
  end

  // Fold the angle into the CORDIC range
  logic signed [17:0] t_ang;
  zang_t              z0, z_init;
  logic               flip_init;
  always_comb begin
    if (cmd_i.sel_pitch) t_ang = {pitch_q[16], pitch_q};
    else if (yaw_q >= 17'(HalfTurn)) t_ang = $signed({1'b0, yaw_q}) - 18'sd92160;
    else t_ang = $signed({1'b0, yaw_q});
    z0 = zang_t'({t_ang, 8'd0});
    if (z0 > Deg90Z) begin
      z_init = z0 - Deg180Z;
      flip_init = 1'b1;
    end else if (z0 < -Deg90Z) begin
      z_init = z0 + Deg180Z;
      flip_init = 1'b1;
    end else begin
      z_init = z0;
      flip_init = 1'b0;
    end
  end

  // One rotation step
  trig_t dxs, dys;
  assign dxs = y_q >>> cmd_i.step_idx;
  assign dys = x_q >>> cmd_i.step_idx;

  // Saturate and unfold the rotated vector
  trig_t xs, ys;
  always_comb begin
    if (x_q > OneT) xs = OneT;
    else if (x_q < -OneT) xs = -OneT;
    else xs = x_q;
    if (y_q > OneT) ys = OneT;
    else if (y_q < -OneT) ys = -OneT;
    else ys = y_q;
    if (flip_q) begin
      xs = -xs;
      ys = -ys;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cor_init) begin
      x_q    <= trig_t'(CordGain);
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip_init;
    end else if (cmd_i.cor_step) begin
      if (z_q >= 0) begin
        x_q <= x_q - dxs;
        y_q <= y_q + dys;
        z_q <= z_q - atan_q16(cmd_i.step_idx);
      end else begin
        x_q <= x_q + dxs;
        y_q <= y_q - dys;
        z_q <= z_q + atan_q16(cmd_i.step_idx);
      end
    end
    if (cmd_i.save_yaw) begin
      cy_q <= xs;
      sy_q <= ys;
    end
    if (cmd_i.save_pitch) begin
      cp_q <= xs;
      sp_q <= ys;
    end
  end

  // Products, signs folded into the first operand; g is -1 when cos pitch < 0
  logic  g_neg;
  trig_t mul_a, mul_b;
  assign g_neg = cp_q[31];
  always_comb begin
    case (cmd_i.mul_idx)
      2'd0: begin
        mul_a = cy_q;
        mul_b = cp_q;
      end
      2'd1: begin
        mul_a = sy_q;
        mul_b = cp_q;
      end
      2'd2: begin
        mul_a = g_neg ? cy_q : -cy_q;
        mul_b = sp_q;
      end
      default: begin
        mul_a = g_neg ? sy_q : -sy_q;
        mul_b = sp_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.res_en) begin
      case (cmd_i.res_idx)
        2'd0:    fx_q <= q14_from60(prod_q);
        2'd1:    fz_q <= q14_from60(prod_q);
        2'd2:    ux_q <= q14_from60(prod_q);
        default: uz_q <= q14_from60(prod_q);
      endcase
    end
  end

  // Output word
  logic signed [32:0] sy_w, cy_w, cp_w;
  assign sy_w = {sy_q[31], sy_q};
  assign cy_w = {cy_q[31], cy_q};
  assign cp_w = {cp_q[31], cp_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      front_x_o   <= fx_q;
      front_y_o   <= q14_from30({sp_q[31], sp_q});
      front_z_o   <= fz_q;
      right_x_o   <= q14_from30(g_neg ? sy_w : -sy_w);
      right_z_o   <= q14_from30(g_neg ? -cy_w : cy_w);
      up_x_o      <= ux_q;
      up_y_o      <= q14_from30(g_neg ? -cp_w : cp_w);
      up_z_o      <= uz_q;
      yaw_now_o   <= yaw_q;
      pitch_now_o <= pitch_q;
    end
  end

endmodule
